// ===== hdl/bgme_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Broadcast group member enumerator package
// Shared widths, register and status codes, microcode types and step names.
// ----------------------------------------------------------------------------
package bgme_pkg;

    localparam int ID_W            = 6;
    localparam int MASK_W          = 4;
    localparam int SIZE_W          = 7;
    localparam int STAT_W          = 2;
    localparam int HW_AXES         = 4;
    localparam int AX_W            = 2;
    localparam int CNT_W           = 3;
    localparam int PC_W            = 4;
    localparam int MAX_AXES        = 4;
    localparam int MAX_USED        = (MAX_AXES < HW_AXES) ? MAX_AXES : HW_AXES;
    localparam int MAX_DEVICES_DEF = 64;
    localparam int COUNT_W         = 3;
    localparam int IN_DATA_W       = 16;
    localparam int OUT_DATA_W      = 8;
    localparam int APB_DATA_W      = 32;
    localparam int PADDR_W         = 5;
    localparam int REG_IDX_W       = 3;

    typedef logic [HW_AXES-1:0][SIZE_W-1:0] size_vec_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_AXIS_COUNT  = 3'd0,
        REG_AXIS_SIZE_0 = 3'd1,
        REG_AXIS_SIZE_1 = 3'd2,
        REG_AXIS_SIZE_2 = 3'd3,
        REG_AXIS_SIZE_3 = 3'd4
    } cfg_reg_t;

    localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_RANGE    = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_OVERSIZE = 2'd2;

    // Datapath operations selected by the control word.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_PROD,
        OP_STR_INIT,
        OP_STRIDE,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_END,
        OP_HORN_INIT,
        OP_HORNER,
        OP_DELTA_INIT,
        OP_DELTA,
        OP_EMIT,
        OP_ERR_OVERSIZE,
        OP_ERR_RANGE
    } op_t;

    // Jump conditions.
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_AX_NLAST,
        C_AX_NZ,
        C_CNT_NLAST,
        C_OVF,
        C_RANGE,
        C_EMIT_MORE
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic no_input;
        logic ax_nlast;
        logic ax_nz;
        logic cnt_nlast;
        logic ovf;
        logic range_err;
        logic emit_more;
    } dp_flags_t;

    // Program steps.
    localparam logic [PC_W-1:0] STEP_IDLE       = 4'd0;
    localparam logic [PC_W-1:0] STEP_PROD       = 4'd1;
    localparam logic [PC_W-1:0] STEP_CHK_SIZE   = 4'd2;
    localparam logic [PC_W-1:0] STEP_CHK_RANGE  = 4'd3;
    localparam logic [PC_W-1:0] STEP_STRIDE     = 4'd4;
    localparam logic [PC_W-1:0] STEP_DIV_INIT   = 4'd5;
    localparam logic [PC_W-1:0] STEP_DIV_STEP   = 4'd6;
    localparam logic [PC_W-1:0] STEP_DIV_END    = 4'd7;
    localparam logic [PC_W-1:0] STEP_HORN_INIT  = 4'd8;
    localparam logic [PC_W-1:0] STEP_HORNER     = 4'd9;
    localparam logic [PC_W-1:0] STEP_DELTA_INIT = 4'd10;
    localparam logic [PC_W-1:0] STEP_DELTA      = 4'd11;
    localparam logic [PC_W-1:0] STEP_EMIT       = 4'd12;
    localparam logic [PC_W-1:0] STEP_DONE       = 4'd13;
    localparam logic [PC_W-1:0] STEP_ERR_SIZE   = 4'd14;
    localparam logic [PC_W-1:0] STEP_ERR_RANGE  = 4'd15;

endpackage

// ===== hdl/bgme_useq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Microcode sequencer
// Step counter, control store and conditional jump logic.
// ----------------------------------------------------------------------------
module bgme_useq (
    input  logic                clk,
    input  logic                rst_n,
    input  bgme_pkg::dp_flags_t flags,
    output bgme_pkg::ucode_t    cw,
    output logic                in_ready
);
    import bgme_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            take_jump;

    // Control store: one word per step.
    always_comb
    begin
        case (pc_reg)
            STEP_IDLE:       cw = '{OP_LOAD,         C_NO_INPUT,  STEP_IDLE};
            STEP_PROD:       cw = '{OP_PROD,         C_AX_NLAST,  STEP_PROD};
            STEP_CHK_SIZE:   cw = '{OP_NOP,          C_OVF,       STEP_ERR_SIZE};
            STEP_CHK_RANGE:  cw = '{OP_STR_INIT,     C_RANGE,     STEP_ERR_RANGE};
            STEP_STRIDE:     cw = '{OP_STRIDE,       C_AX_NZ,     STEP_STRIDE};
            STEP_DIV_INIT:   cw = '{OP_DIV_INIT,     C_NEVER,     STEP_IDLE};
            STEP_DIV_STEP:   cw = '{OP_DIV_STEP,     C_CNT_NLAST, STEP_DIV_STEP};
            STEP_DIV_END:    cw = '{OP_DIV_END,      C_AX_NZ,     STEP_DIV_INIT};
            STEP_HORN_INIT:  cw = '{OP_HORN_INIT,    C_NEVER,     STEP_IDLE};
            STEP_HORNER:     cw = '{OP_HORNER,       C_AX_NLAST,  STEP_HORNER};
            STEP_DELTA_INIT: cw = '{OP_DELTA_INIT,   C_NEVER,     STEP_IDLE};
            STEP_DELTA:      cw = '{OP_DELTA,        C_AX_NZ,     STEP_DELTA};
            STEP_EMIT:       cw = '{OP_EMIT,         C_EMIT_MORE, STEP_EMIT};
            STEP_DONE:       cw = '{OP_NOP,          C_ALWAYS,    STEP_IDLE};
            STEP_ERR_SIZE:   cw = '{OP_ERR_OVERSIZE, C_ALWAYS,    STEP_EMIT};
            STEP_ERR_RANGE:  cw = '{OP_ERR_RANGE,    C_ALWAYS,    STEP_EMIT};
            default:         cw = '{OP_NOP,          C_ALWAYS,    STEP_IDLE};
        endcase
    end

    always_comb
    begin
        case (cw.cond)
            C_NEVER:     take_jump = 1'b0;
            C_ALWAYS:    take_jump = 1'b1;
            C_NO_INPUT:  take_jump = flags.no_input;
            C_AX_NLAST:  take_jump = flags.ax_nlast;
            C_AX_NZ:     take_jump = flags.ax_nz;
            C_CNT_NLAST: take_jump = flags.cnt_nlast;
            C_OVF:       take_jump = flags.ovf;
            C_RANGE:     take_jump = flags.range_err;
            C_EMIT_MORE: take_jump = flags.emit_more;
            default:     take_jump = 1'b0;
        endcase
    end

    assign pc_next  = take_jump ? cw.target : pc_reg + PC_W'(1);
    assign in_ready = (cw.op == OP_LOAD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ===== hdl/bgme_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Enumerator datapath
// Shared multiplier, restoring divider step, per-axis registers and the
// odometer that walks the broadcast axes, with the result register.
// ----------------------------------------------------------------------------
module bgme_dpath #(
    parameter int MAX_DEVICES = bgme_pkg::MAX_DEVICES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bgme_pkg::ucode_t              cw,
    output bgme_pkg::dp_flags_t           flags,
    input  logic                          in_fire,
    input  logic [bgme_pkg::ID_W-1:0]     req_dev,
    input  logic [bgme_pkg::MASK_W-1:0]   broadcast_mask,
    input  logic [bgme_pkg::HW_AXES-1:0]  axis_on,
    input  bgme_pkg::size_vec_t           axis_size,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bgme_pkg::ID_W-1:0]     member_id,
    output logic [bgme_pkg::STAT_W-1:0]   status,
    output logic                          last
);
    import bgme_pkg::*;

    localparam int DEV_W = $clog2(MAX_DEVICES + 1);
    localparam int MUL_W = DEV_W + SIZE_W;
    localparam int CMP_W = (DEV_W > ID_W) ? DEV_W : ID_W;

    // Control registers.
    logic [AX_W-1:0]   ax_reg,   ax_next;
    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    logic              ovf_reg,  ovf_next;
    logic [STAT_W-1:0] err_reg,  err_next;
    logic              oval_reg, oval_next;

    // Working registers.
    logic [ID_W-1:0]                    q_reg,      q_next;
    logic [SIZE_W-1:0]                  part_reg,   part_next;
    logic [DEV_W-1:0]                   total_reg,  total_next;
    logic [HW_AXES-1:0]                 bc_reg,     bc_next;
    logic [DEV_W-1:0]                   acc_reg,    acc_next;
    logic [DEV_W-1:0]                   id_reg,     id_next;
    logic [HW_AXES-1:0][DEV_W-1:0]      stride_reg, stride_next;
    logic [HW_AXES-1:0][DEV_W-1:0]      delta_reg,  delta_next;
    logic [HW_AXES-1:0][SIZE_W-1:0]     idx_reg,    idx_next;
    logic [ID_W-1:0]                    mem_reg,    mem_next;
    logic [STAT_W-1:0]                  stat_reg,   stat_next;
    logic                               last_reg,   last_next;

    logic [SIZE_W-1:0] cur_size;
    logic [DEV_W-1:0]  mul_a;
    logic [MUL_W-1:0]  mul_p;
    logic [SIZE_W:0]   trial;
    logic              trial_ge;
    logic [ID_W-1:0]   fixed_term;
    logic              out_free;
    logic              found;
    logic [AX_W-1:0]   sel;

    assign cur_size = axis_size[ax_reg];
    assign out_free = !oval_reg || out_ready;

    always_comb
    begin
        case (cw.op)
            OP_PROD:   mul_a = total_reg;
            OP_STRIDE: mul_a = acc_reg;
            OP_HORNER: mul_a = id_reg;
            OP_DELTA:  mul_a = stride_reg[ax_reg];
            default:   mul_a = '0;
        endcase
    end

    assign mul_p      = MUL_W'(mul_a) * MUL_W'(cur_size);
    assign trial      = {part_reg, q_reg[ID_W-1]};
    assign trial_ge   = (trial >= (SIZE_W+1)'(cur_size));
    assign fixed_term = bc_reg[ax_reg] ? '0 : idx_reg[ax_reg][ID_W-1:0];

    // Highest broadcast axis that can still step without wrapping.
    always_comb
    begin
        found = 1'b0;
        sel   = '0;
        for (int j = HW_AXES - 1; j >= 0; j--)
        begin
            if (!found && bc_reg[j] && (idx_reg[j] != axis_size[j] - SIZE_W'(1)))
            begin
                found = 1'b1;
                sel   = AX_W'(j);
            end
        end
    end

    always_comb
    begin
        ax_next     = ax_reg;
        cnt_next    = cnt_reg;
        ovf_next    = ovf_reg;
        err_next    = err_reg;
        oval_next   = oval_reg && !out_ready;
        q_next      = q_reg;
        part_next   = part_reg;
        total_next  = total_reg;
        bc_next     = bc_reg;
        acc_next    = acc_reg;
        id_next     = id_reg;
        stride_next = stride_reg;
        delta_next  = delta_reg;
        idx_next    = idx_reg;
        mem_next    = mem_reg;
        stat_next   = stat_reg;
        last_next   = last_reg;

        case (cw.op)
            OP_LOAD:
            begin
                if (in_fire)
                begin
                    q_next     = req_dev;
                    bc_next    = broadcast_mask & axis_on;
                    total_next = DEV_W'(1);
                    ovf_next   = 1'b0;
                    err_next   = STATUS_OK;
                    ax_next    = '0;
                end
            end
            OP_PROD:
            begin
                if (mul_p > MUL_W'(MAX_DEVICES))
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    total_next = DEV_W'(mul_p);
                end
                ax_next = ax_reg + AX_W'(1);
            end
            OP_STR_INIT:
            begin
                acc_next = DEV_W'(1);
                ax_next  = AX_W'(HW_AXES - 1);
            end
            OP_STRIDE:
            begin
                stride_next[ax_reg] = acc_reg;
                acc_next            = DEV_W'(mul_p);
                ax_next             = ax_reg - AX_W'(1);
            end
            OP_DIV_INIT:
            begin
                part_next = '0;
                cnt_next  = '0;
            end
            OP_DIV_STEP:
            begin
                part_next = trial_ge ? SIZE_W'(trial - (SIZE_W+1)'(cur_size))
                                     : SIZE_W'(trial);
                q_next    = {q_reg[ID_W-2:0], trial_ge};
                cnt_next  = cnt_reg + CNT_W'(1);
            end
            OP_DIV_END:
            begin
                idx_next[ax_reg] = part_reg;
                ax_next          = ax_reg - AX_W'(1);
            end
            OP_HORN_INIT:
            begin
                id_next = '0;
                ax_next = '0;
            end
            OP_HORNER:
            begin
                id_next = DEV_W'(mul_p + MUL_W'(fixed_term));
                ax_next = ax_reg + AX_W'(1);
            end
            OP_DELTA_INIT:
            begin
                acc_next = '0;
                ax_next  = AX_W'(HW_AXES - 1);
                for (int k = 0; k < HW_AXES; k++)
                begin
                    if (bc_reg[k])
                    begin
                        idx_next[k] = '0;
                    end
                end
            end
            OP_DELTA:
            begin
                // Step on this axis, minus the spans of the faster axes that wrap.
                delta_next[ax_reg] = stride_reg[ax_reg] - acc_reg;
                if (bc_reg[ax_reg])
                begin
                    acc_next = acc_reg + DEV_W'(mul_p) - stride_reg[ax_reg];
                end
                ax_next = ax_reg - AX_W'(1);
            end
            OP_EMIT:
            begin
                if (out_free)
                begin
                    oval_next = 1'b1;
                    if (err_reg != STATUS_OK)
                    begin
                        mem_next  = '0;
                        stat_next = err_reg;
                        last_next = 1'b1;
                    end
                    else
                    begin
                        mem_next  = ID_W'(id_reg);
                        stat_next = STATUS_OK;
                        last_next = !found;
                        if (found)
                        begin
                            id_next = id_reg + delta_reg[sel];
                            for (int k = 0; k < HW_AXES; k++)
                            begin
                                if (bc_reg[k] && (k > int'(sel)))
                                begin
                                    idx_next[k] = '0;
                                end
                            end
                            idx_next[sel] = idx_reg[sel] + SIZE_W'(1);
                        end
                    end
                end
            end
            OP_ERR_OVERSIZE: err_next = STATUS_OVERSIZE;
            OP_ERR_RANGE:    err_next = STATUS_RANGE;
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        flags.no_input  = !in_fire;
        flags.ax_nlast  = (ax_reg != AX_W'(HW_AXES - 1));
        flags.ax_nz     = (ax_reg != '0);
        flags.cnt_nlast = (cnt_reg != CNT_W'(ID_W - 1));
        flags.ovf       = ovf_reg;
        flags.range_err = (CMP_W'(q_reg) >= CMP_W'(total_reg));
        flags.emit_more = !(out_free && ((err_reg != STATUS_OK) || !found));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ax_reg   <= '0;
            cnt_reg  <= '0;
            ovf_reg  <= 1'b0;
            err_reg  <= STATUS_OK;
            oval_reg <= 1'b0;
        end
        else
        begin
            ax_reg   <= ax_next;
            cnt_reg  <= cnt_next;
            ovf_reg  <= ovf_next;
            err_reg  <= err_next;
            oval_reg <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg      <= q_next;
        part_reg   <= part_next;
        total_reg  <= total_next;
        bc_reg     <= bc_next;
        acc_reg    <= acc_next;
        id_reg     <= id_next;
        stride_reg <= stride_next;
        delta_reg  <= delta_next;
        idx_reg    <= idx_next;
        mem_reg    <= mem_next;
        stat_reg   <= stat_next;
        last_reg   <= last_next;
    end

    assign out_valid = oval_reg;
    assign member_id = mem_reg;
    assign status    = stat_reg;
    assign last      = last_reg;

endmodule

// ===== hdl/broadcast_group_member_enumerator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Broadcast group member enumerator
// Lists the flat ids of every device that shares a broadcast group with a
// given device in a configured hierarchy of up to four axes.
// ----------------------------------------------------------------------------
// Usage. The hierarchy is set through the APB port: axis_count at 0x0 and the
// four axis sizes at 0x4 to 0x10. Registers reset to a one-axis hierarchy of
// one device and must only be written while the block is idle.
// A request beat on the s_ channel carries a device id and a broadcast mask.
// The block answers with one beat per group member on the m_ channel, the
// hierarchy's own axis order setting the order of the members, and tlast
// marks the final beat. A device id outside the hierarchy, or a hierarchy of
// more than MAX_DEVICES devices, gives a single beat with an error status.
// Timing. s_tready is high only while the sequencer waits for a request.
// After acceptance the microcode program forms the hierarchy size, checks
// size and range (a failed check goes straight to its error beat), builds
// the strides, divides the id into axis indices by shift and subtract steps,
// then forms the first member and the odometer deltas. Members then follow
// one per cycle into the result register unless m_tready stalls them.
// Stalls. When m_tready is low the result register holds its beat and the
// program waits at its emit step. After reset no beat is pending and the
// block is ready for a request.
// ----------------------------------------------------------------------------
module broadcast_group_member_enumerator #(
    parameter int MAX_DEVICES = bgme_pkg::MAX_DEVICES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Request channel.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bgme_pkg::IN_DATA_W-1:0]    s_tdata,   // [5:0] dev_id, [9:6] broadcast_mask
    // Result channel.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bgme_pkg::OUT_DATA_W-1:0]   m_tdata,   // [5:0] member_id
    output logic [bgme_pkg::STAT_W-1:0]       m_tuser,   // [1:0] status
    output logic                              m_tlast,
    // Configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bgme_pkg::PADDR_W-1:0]      paddr,
    input  logic [bgme_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [bgme_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import bgme_pkg::*;

    // Configuration registers.
    logic [COUNT_W-1:0]             count_reg;
    logic [HW_AXES-1:0][SIZE_W-1:0] size_reg;
    logic                           cfg_wr;
    logic [REG_IDX_W-1:0]           reg_idx;

    logic [COUNT_W-1:0]  used_axes;
    logic [HW_AXES-1:0]  axis_on;
    size_vec_t           axis_size;

    ucode_t              cw;
    dp_flags_t           flags;
    logic                in_fire;
    logic [ID_W-1:0]     member_id;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_W'(1);
            size_reg  <= {HW_AXES{SIZE_W'(1)}};
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_AXIS_COUNT:  count_reg   <= pwdata[COUNT_W-1:0];
                REG_AXIS_SIZE_0: size_reg[0] <= pwdata[SIZE_W-1:0];
                REG_AXIS_SIZE_1: size_reg[1] <= pwdata[SIZE_W-1:0];
                REG_AXIS_SIZE_2: size_reg[2] <= pwdata[SIZE_W-1:0];
                REG_AXIS_SIZE_3: size_reg[3] <= pwdata[SIZE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_AXIS_COUNT:  prdata = APB_DATA_W'(count_reg);
            REG_AXIS_SIZE_0: prdata = APB_DATA_W'(size_reg[0]);
            REG_AXIS_SIZE_1: prdata = APB_DATA_W'(size_reg[1]);
            REG_AXIS_SIZE_2: prdata = APB_DATA_W'(size_reg[2]);
            REG_AXIS_SIZE_3: prdata = APB_DATA_W'(size_reg[3]);
            default:         prdata = '0;
        endcase
    end

    // A count of zero means one axis; it saturates at the number of size
    // registers. Unused axes and zero sizes behave as size one.
    always_comb
    begin
        if (count_reg == '0)
        begin
            used_axes = COUNT_W'(1);
        end
        else if (count_reg > COUNT_W'(MAX_USED))
        begin
            used_axes = COUNT_W'(MAX_USED);
        end
        else
        begin
            used_axes = count_reg;
        end
        for (int k = 0; k < HW_AXES; k++)
        begin
            axis_on[k] = (k < int'(used_axes));
            if (axis_on[k] && (size_reg[k] != '0))
            begin
                axis_size[k] = size_reg[k];
            end
            else
            begin
                axis_size[k] = SIZE_W'(1);
            end
        end
    end

    assign in_fire = s_tvalid && s_tready;

    bgme_useq u_useq (
        .clk      (clk),
        .rst_n    (rst_n),
        .flags    (flags),
        .cw       (cw),
        .in_ready (s_tready)
    );

    bgme_dpath #(
        .MAX_DEVICES (MAX_DEVICES)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cw             (cw),
        .flags          (flags),
        .in_fire        (in_fire),
        .req_dev        (s_tdata[ID_W-1:0]),
        .broadcast_mask (s_tdata[ID_W+MASK_W-1:ID_W]),
        .axis_on        (axis_on),
        .axis_size      (axis_size),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .member_id      (member_id),
        .status         (m_tuser),
        .last           (m_tlast)
    );

    assign m_tdata = OUT_DATA_W'(member_id);

endmodule

// ===== hdl/bgme_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Enumerator port checker
// Watches the top-level ports for result and request ordering rules.
// ----------------------------------------------------------------------------
module bgme_port_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [bgme_pkg::OUT_DATA_W-1:0]   m_tdata,
    input logic [bgme_pkg::STAT_W-1:0]       m_tuser,
    input logic                              m_tlast
);
    import bgme_pkg::*;

    // A stalled result beat holds its contents.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                  && $stable(m_tuser) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // An error beat is the last of its run and carries a zero member id.
    a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != STATUS_OK) |-> m_tlast && (m_tdata == '0))
        else $error("error beat not last or member id not zero");

    // Only the defined status codes appear.
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == STATUS_OK) || (m_tuser == STATUS_RANGE)
                     || (m_tuser == STATUS_OVERSIZE))
        else $error("undefined status code");

    // A request is worked through before the next one is taken.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another is in progress");

endmodule

bind broadcast_group_member_enumerator bgme_port_checker u_bgme_checker (.*);
